// ===== sv/smd_pkg.sv =====
package smd_pkg;

  // clock value carried between the time keeper and the display decode
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  // drive levels for one scan step
  typedef struct packed {
    logic [3:0] digit_enables;
    logic [6:0] segments;
    logic [7:0] row_enables;
    logic [7:0] column_drive;
    logic       blink_fast;
    logic       blink_slow;
  } disp_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_t;

  localparam int unsigned DIGITS     = 4;
  localparam int unsigned ROW_BITS   = 3;
  localparam int unsigned PATTERN_W  = 64;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [6:0]  SEG_BLANK  = 7'h7F;

  localparam logic [4:0]  HOUR_RESET = 5'd12;
  localparam logic [5:0]  MIN_RESET  = 6'd34;
  localparam logic [5:0]  SEC_RESET  = 6'd58;
  localparam logic [PATTERN_W-1:0] PATTERN_RESET = 64'h0807_0605_0403_0201;

  // common-anode codes for 0..9, bit 7 is the unused decimal point
  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // split a value below 64 into decimal tens and units
  function automatic bcd_t bcd_split(input logic [5:0] v);
    bcd_t b;
    if (v >= 6'd60) begin
      b.tens = 4'd6;
    end else if (v >= 6'd50) begin
      b.tens = 4'd5;
    end else if (v >= 6'd40) begin
      b.tens = 4'd4;
    end else if (v >= 6'd30) begin
      b.tens = 4'd3;
    end else if (v >= 6'd20) begin
      b.tens = 4'd2;
    end else if (v >= 6'd10) begin
      b.tens = 4'd1;
    end else begin
      b.tens = 4'd0;
    end
    b.units = 4'(v - 6'(6'(b.tens) * 6'd10));
    return b;
  endfunction

  // segment pattern for one decimal digit, blank above nine
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    if (d <= 4'd9) begin
      s = SEG_CODE[d][6:0];
    end else begin
      s = SEG_BLANK;
    end
    return s;
  endfunction

endpackage

// ===== sv/smd_time.sv =====
module smd_time
  import smd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  output time_t time_next
);

  time_t now;

  // one-second advance with carries into minutes and hours
  always_comb begin
    time_next = now;
    if (step) begin
      if (now.seconds >= SEC_LAST) begin
        time_next.seconds = '0;
        if (now.minutes >= MIN_LAST) begin
          time_next.minutes = '0;
          if (now.hours >= HOUR_LAST) begin
            time_next.hours = '0;
          end else begin
            time_next.hours = now.hours + 5'd1;
          end
        end else begin
          time_next.minutes = now.minutes + 6'd1;
        end
      end else begin
        time_next.seconds = now.seconds + 6'd1;
      end
    end
  end

  // clock registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now.hours   <= HOUR_RESET;
      now.minutes <= MIN_RESET;
      now.seconds <= SEC_RESET;
    end else begin
      now <= time_next;
    end
  end

endmodule

// ===== sv/smd_scan.sv =====
module smd_scan
  import smd_pkg::*;
#(
  parameter int unsigned ROWS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [PATTERN_W-1:0] matrix_pattern,
  input  time_t                time_next,
  output logic                 first_digit,
  output disp_t                disp_next
);

  logic [1:0]          digit_pos;
  logic [ROW_BITS-1:0] row_pos;
  logic                fast_level;
  logic                slow_level;
  logic [1:0]          digit_pos_next;
  logic [ROW_BITS-1:0] row_pos_next;
  logic                fast_level_next;
  logic                slow_level_next;
  bcd_t                hour_bcd;
  bcd_t                min_bcd;
  logic [3:0]          digit;
  logic [7:0]          row_byte;

  assign first_digit = (digit_pos == 2'd0);

  // pick the digit of HH MM under the scan index
  always_comb begin
    hour_bcd = bcd_split(6'(time_next.hours));
    min_bcd  = bcd_split(time_next.minutes);
    case (digit_pos)
      2'd0:    digit = hour_bcd.tens;
      2'd1:    digit = hour_bcd.units;
      2'd2:    digit = min_bcd.tens;
      default: digit = min_bcd.units;
    endcase
  end

  // matrix row byte for the current row
  assign row_byte = matrix_pattern[{row_pos, 3'b000} +: 8];

  // scan index and blink updates for an accepted tick
  always_comb begin
    fast_level_next = fast_level ^ 1'b1;
    slow_level_next = slow_level ^ (digit_pos == 2'd0 || digit_pos == 2'd2);
    digit_pos_next  = digit_pos + 2'd1;
    if (row_pos >= ROW_BITS'(ROWS - 1)) begin
      row_pos_next = '0;
    end else begin
      row_pos_next = row_pos + ROW_BITS'(1);
    end
  end

  // drive levels for this step
  always_comb begin
    disp_next.digit_enables = ~(DIGITS'(1) << digit_pos);
    disp_next.segments      = seg_of(digit);
    disp_next.row_enables   = ~(8'd1 << row_pos);
    disp_next.column_drive  = ~row_byte;
    disp_next.blink_fast    = fast_level_next;
    disp_next.blink_slow    = slow_level_next;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pos  <= '0;
      row_pos    <= '0;
      fast_level <= 1'b0;
      slow_level <= 1'b0;
    end else if (step) begin
      digit_pos  <= digit_pos_next;
      row_pos    <= row_pos_next;
      fast_level <= fast_level_next;
      slow_level <= slow_level_next;
    end
  end

endmodule

// ===== sv/scanned_clock_and_matrix_display.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  tick
// cfg       input      cfg_write_en         cfg_write_data (matrix_pattern)
// out       output     out_valid/out_ready  digit_enables segments row_enables
//                                            column_drive blink_fast blink_slow
//                                            hours_now minutes_now seconds_now
//
// one request per cycle while in_ready is high; a tick request passes the input
// register, then the result register, which raises out_valid. a request with tick low
// is taken and dropped without a result.
// rst is synchronous: clock 12:34:58, scan indices zero, blink levels low,
// matrix pattern rows 1..8. when out_valid is high and out_ready low the result register
// holds and the input register fills, after which in_ready drops.
module scanned_clock_and_matrix_display
  import smd_pkg::*;
#(
  parameter int unsigned ROWS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 tick,
  input  logic                 cfg_write_en,
  input  logic [PATTERN_W-1:0] cfg_write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           digit_enables,
  output logic [6:0]           segments,
  output logic [7:0]           row_enables,
  output logic [7:0]           column_drive,
  output logic                 blink_fast,
  output logic                 blink_slow,
  output logic [4:0]           hours_now,
  output logic [5:0]           minutes_now,
  output logic [5:0]           seconds_now
);

  logic [PATTERN_W-1:0] matrix_pattern;
  logic                 req_valid;
  logic                 req_tick;
  logic                 advance;
  logic                 step;
  logic                 first_digit;
  time_t                time_next;
  disp_t                disp_next;
  time_t                time_q;
  disp_t                disp_q;

  // result register free to load
  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;
  assign step     = advance && req_valid && req_tick;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_pattern <= PATTERN_RESET;
    end else if (cfg_write_en) begin
      matrix_pattern <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      req_tick <= tick;
    end
  end

  smd_time u_time (
    .clk       (clk),
    .rst       (rst),
    .step      (step && first_digit),
    .time_next (time_next)
  );

  smd_scan #(
    .ROWS (ROWS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .matrix_pattern (matrix_pattern),
    .time_next      (time_next),
    .first_digit    (first_digit),
    .disp_next      (disp_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid && req_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      time_q <= time_next;
      disp_q <= disp_next;
    end
  end

  assign digit_enables = disp_q.digit_enables;
  assign segments      = disp_q.segments;
  assign row_enables   = disp_q.row_enables;
  assign column_drive  = disp_q.column_drive;
  assign blink_fast    = disp_q.blink_fast;
  assign blink_slow    = disp_q.blink_slow;
  assign hours_now     = time_q.hours;
  assign minutes_now   = time_q.minutes;
  assign seconds_now   = time_q.seconds;

  // exactly one digit and one row driven
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~digit_enables) && $onehot(~row_enables))
    else $error("digit or row enable not one-hot");

  // clock stays in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hours_now <= HOUR_LAST) && (minutes_now <= MIN_LAST) &&
                  (seconds_now <= SEC_LAST))
    else $error("clock value out of range");

  // fast blink flips between consecutive results
  a_fast_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 (out_valid && $changed(digit_enables)) |->
      blink_fast != $past(blink_fast))
    else $error("fast blink did not toggle");

  // a stalled result keeps its seconds value and fast blink level
  a_hold_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(seconds_now) && $stable(blink_fast))
    else $error("result changed while stalled");

endmodule

// ===== sim/tb_scanned_clock_and_matrix_display.sv =====
`timescale 1ns / 1ps

module tb_scanned_clock_and_matrix_display;
  import smd_pkg::*;

  localparam int unsigned ROW_COUNT = 8;

  // common-anode glyphs for 0..9, decimal point in bit 7
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    disp_t shown;
    time_t clock;
  } scan_result_t;

  // display predictor and store of expected scan results
  class scan_scoreboard;
    time_t                clock_now;
    logic [1:0]           digit_pos;
    logic [2:0]           row_pos;
    logic                 fast_level;
    logic                 slow_level;
    logic [PATTERN_W-1:0] pattern;
    scan_result_t         expected_q[$];
    int                   errors;

    function new();
      clock_now.hours   = HOUR_RESET;
      clock_now.minutes = MIN_RESET;
      clock_now.seconds = SEC_RESET;
      digit_pos    = '0;
      row_pos      = '0;
      fast_level   = 1'b0;
      slow_level   = 1'b0;
      pattern      = PATTERN_RESET;
      errors       = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function logic [6:0] glyph(input logic [3:0] d);
      if (d > 4'd9) return 7'h7F;
      return DIGIT_GLYPH[d][6:0];
    endfunction

    // one second forward, wrapping 60 / 60 / 24
    function void advance_second();
      if (clock_now.seconds == 6'd59) begin
        clock_now.seconds = '0;
        if (clock_now.minutes == 6'd59) begin
          clock_now.minutes = '0;
          if (clock_now.hours == 5'd23) begin
            clock_now.hours = '0;
          end else begin
            clock_now.hours++;
          end
        end else begin
          clock_now.minutes++;
        end
      end else begin
        clock_now.seconds++;
      end
    endfunction

    // an accepted request; only a tick yields a scan result
    function void note_request(input logic tick_in);
      scan_result_t r;
      logic [3:0] digit;
      if (!tick_in) return;
      if (digit_pos == 2'd0) advance_second();
      fast_level = ~fast_level;
      if (digit_pos == 2'd0 || digit_pos == 2'd2) slow_level = ~slow_level;
      case (digit_pos)
        2'd0: digit = 4'(clock_now.hours / 10);
        2'd1: digit = 4'(clock_now.hours % 10);
        2'd2: digit = 4'(clock_now.minutes / 10);
        default: digit = 4'(clock_now.minutes % 10);
      endcase
      r.shown.digit_enables = ~(4'b0001 << digit_pos);
      r.shown.segments      = glyph(digit);
      r.shown.row_enables   = ~(8'b0000_0001 << row_pos);
      r.shown.column_drive  = ~pattern[row_pos*8 +: 8];
      r.shown.blink_fast    = fast_level;
      r.shown.blink_slow    = slow_level;
      r.clock               = clock_now;
      expected_q.push_back(r);
      digit_pos = digit_pos + 2'd1;
      row_pos   = (row_pos == 3'(ROW_COUNT - 1)) ? 3'd0 : row_pos + 3'd1;
    endfunction

    task compare_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(input scan_result_t got);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("scan result with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("digit_enables", got.shown.digit_enables, want.shown.digit_enables);
      compare_field("segments", got.shown.segments, want.shown.segments);
      compare_field("row_enables", got.shown.row_enables, want.shown.row_enables);
      compare_field("column_drive", got.shown.column_drive, want.shown.column_drive);
      compare_field("blink_fast", got.shown.blink_fast, want.shown.blink_fast);
      compare_field("blink_slow", got.shown.blink_slow, want.shown.blink_slow);
      compare_field("hours_now", got.clock.hours, want.clock.hours);
      compare_field("minutes_now", got.clock.minutes, want.clock.minutes);
      compare_field("seconds_now", got.clock.seconds, want.clock.seconds);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 tick = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [PATTERN_W-1:0] cfg_write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [3:0]           digit_enables;
  logic [6:0]           segments;
  logic [7:0]           row_enables;
  logic [7:0]           column_drive;
  logic                 blink_fast;
  logic                 blink_slow;
  logic [4:0]           hours_now;
  logic [5:0]           minutes_now;
  logic [5:0]           seconds_now;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  scan_scoreboard tally = new();

  scanned_clock_and_matrix_display #(.ROWS(ROW_COUNT)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tick(tick),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digit_enables(digit_enables),
    .segments(segments),
    .row_enables(row_enables),
    .column_drive(column_drive),
    .blink_fast(blink_fast),
    .blink_slow(blink_slow),
    .hours_now(hours_now),
    .minutes_now(minutes_now),
    .seconds_now(seconds_now)
  );

  always #4 clk = ~clk;

  // result side: check on handshake, then pick next ready level
  always @(posedge clk) begin
    scan_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.shown = '{digit_enables, segments, row_enables, column_drive,
                    blink_fast, blink_slow};
      got.clock = '{hours_now, minutes_now, seconds_now};
      tally.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request, with a random gap ahead of it
  task automatic send_request(input logic tick_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= tick_in;
    do @(posedge clk); while (!in_ready);
    tally.note_request(tick_in);
  endtask

  // wait for every scan result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pattern(input logic [PATTERN_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    tally.pattern = value;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // idle mode per phase: none, sender, receiver, both
  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // timeout
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [PATTERN_W-1:0] patterns [8];
    int ticks_sent;
    logic t;
    patterns[0] = '0;
    patterns[1] = '1;
    patterns[2] = {$urandom, $urandom};
    patterns[3] = 64'hAA55_AA55_55AA_55AA;
    patterns[4] = {$urandom, $urandom};
    patterns[5] = 64'h8000_0000_0000_0001;
    patterns[6] = {$urandom, $urandom};
    patterns[7] = 64'hFF00_FF00_00FF_00FF;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pattern, idle ticks mixed in, rows and seconds wrap
    for (int i = 0; i < 24; i++) send_request(i % 5 != 2);
    drain();

    // random phases over pattern settings and idle modes
    for (int ph = 0; ph < 8; ph++) begin
      write_pattern(patterns[ph]);
      ticks_sent = 0;
      while (ticks_sent < 150) begin
        // bursts of 25, some of them without idling
        if (ticks_sent % 25 == 0)
          set_idling(($urandom_range(3) == 0) ? 0 : ph % 4);
        t = ($urandom_range(99) < 85);
        send_request(t);
        if (t) ticks_sent++;
      end
      drain();
    end
    repeat (10) @(posedge clk);

    if (tally.pending() != 0)
      tally.report_mismatch($sformatf("%0d scan results never arrived", tally.pending()));
    if (tally.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/smd_pkg.sv
sv/smd_time.sv
sv/smd_scan.sv
sv/scanned_clock_and_matrix_display.sv
sim/tb_scanned_clock_and_matrix_display.sv
